### sv/mmsc_pkg.sv
// ----------------------------------------------------------------------------
// mmsc_pkg
// types, codes and check arithmetic shared by the serial check unit
// ----------------------------------------------------------------------------
`default_nettype none

package mmsc_pkg;

	// scheme codes held in the mode register
	typedef enum logic [2:0] {
		MODE_CCITT16 = 3'd0,
		MODE_CRC9    = 3'd1,
		MODE_CRC32   = 3'd2,
		MODE_CRC7    = 3'd3,
		MODE_CRC8    = 3'd4,
		MODE_SUM31   = 3'd5
	} crc_mode_t;

	localparam int unsigned MODE_W  = 3;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;
	localparam int unsigned CHECK_W = 32;

	// register index, taken from byte address bit 2
	localparam logic REG_CRC_MODE = 1'b0;

	localparam logic [15:0] POLY_CCITT16 = 16'h1021;
	localparam logic [8:0]  POLY_CRC9    = 9'h059;
	localparam logic [31:0] POLY_CRC32   = 32'h04C1_1DB7;
	localparam logic [6:0]  POLY_CRC7    = 7'h27;
	localparam logic [7:0]  POLY_CRC8    = 8'h07;
	localparam logic [15:0] XOR_CCITT16  = 16'hFFFF;
	localparam logic [8:0]  XOR_CRC9     = 9'h1FF;
	localparam logic [4:0]  SUM_MODULUS  = 5'd31;

	// one input transfer held in the input stage
	typedef struct packed {
		logic valid;
		logic data_bit;
		logic last_bit;
	} bit_item_t;

	// one shift of the crc register; bits above the scheme width are cleared
	function automatic logic [31:0] crc_next(input logic [31:0] r, input logic b,
			input logic [2:0] m);
		logic [31:0] n;
		n = r;
		case (m)
			MODE_CCITT16: begin
				n = {16'b0, r[14:0], 1'b0};
				if (r[15] ^ b) n[15:0] = n[15:0] ^ POLY_CCITT16;
			end
			MODE_CRC9: begin
				n = {23'b0, r[7:0], 1'b0};
				if (r[8] ^ b) n[8:0] = n[8:0] ^ POLY_CRC9;
			end
			MODE_CRC32: begin
				n = {r[30:0], 1'b0};
				if (r[31] ^ b) n = n ^ POLY_CRC32;
			end
			MODE_CRC7: begin
				n = {25'b0, r[5:0], 1'b0};
				if (r[6] ^ b) n[6:0] = n[6:0] ^ POLY_CRC7;
			end
			MODE_CRC8: begin
				n = {24'b0, r[6:0], 1'b0};
				if (r[7] ^ b) n[7:0] = n[7:0] ^ POLY_CRC8;
			end
			default: n = r;
		endcase
		return n;
	endfunction

	// (s + v) mod 31 for s below 31, using 32 = 1 mod 31
	function automatic logic [4:0] sum_mod31(input logic [4:0] s, input logic [7:0] v);
		logic [8:0] t;
		logic [5:0] f;
		t = {4'b0, s} + {1'b0, v};
		f = {2'b0, t[8:5]} + {1'b0, t[4:0]};
		if (f >= {1'b0, SUM_MODULUS}) f = f - {1'b0, SUM_MODULUS};
		return f[4:0];
	endfunction

	// finished check value, right aligned
	function automatic logic [31:0] check_out(input logic [31:0] r, input logic [4:0] s,
			input logic [2:0] m);
		logic [31:0] v;
		case (m)
			MODE_CCITT16: v = {16'b0, r[15:0] ^ XOR_CCITT16};
			MODE_CRC9:    v = {23'b0, r[8:0] ^ XOR_CRC9};
			MODE_CRC32:   v = {r[7:0], r[15:8], r[23:16], r[31:24]};
			MODE_CRC7:    v = {25'b0, r[6:0]};
			MODE_CRC8:    v = {24'b0, r[7:0]};
			MODE_SUM31:   v = {27'b0, s};
			default:      v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### sv/mmsc_bit_if.sv
// ----------------------------------------------------------------------------
// mmsc_bit_if
// message bit channel: valid/ready with data bit and last marker
// ----------------------------------------------------------------------------
`default_nettype none

interface mmsc_bit_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic last_bit;

	modport source (output valid, output data_bit, output last_bit, input ready);
	modport sink (input valid, input data_bit, input last_bit, output ready);
endinterface

`default_nettype wire

### sv/mmsc_res_if.sv
// ----------------------------------------------------------------------------
// mmsc_res_if
// result channel: valid/ready with the finished check value
// ----------------------------------------------------------------------------
`default_nettype none

interface mmsc_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] check_value;

	modport source (output valid, output check_value, input ready);
	modport sink (input valid, input check_value, output ready);
endinterface

`default_nettype wire

### sv/mmsc_cfg.sv
// ----------------------------------------------------------------------------
// mmsc_cfg
// apb register slave holding the scheme select
// ----------------------------------------------------------------------------
`default_nettype none

module mmsc_cfg
	import mmsc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic      [MODE_W-1:0] crc_mode
);

	logic [MODE_W-1:0] mode_q;
	logic              hit;

	assign hit    = (paddr[2] == REG_CRC_MODE);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CCITT16;
		end else if (psel && penable && pwrite && pready && hit) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	// paddr[1:0] are byte lanes inside the word
	always_comb begin
		prdata = '0;
		if (hit) prdata[MODE_W-1:0] = mode_q;
	end

	assign crc_mode = mode_q;

	logic unused_addr;
	assign unused_addr = ^paddr[1:0];

endmodule

`default_nettype wire

### sv/mmsc_engine.sv
// ----------------------------------------------------------------------------
// mmsc_engine
// check state, single-pass update per bit and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mmsc_engine
	import mmsc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [MODE_W-1:0]  crc_mode,
	input  wire bit_item_t          item_s1,
	input  wire logic               advance,
	output logic                    res_valid,
	output logic      [CHECK_W-1:0] check_value
);

	logic [31:0] shift_q, shift_n;
	logic [7:0]  byte_q, byte_n;
	logic [2:0]  pos_q, pos_n;
	logic [4:0]  sum_q, sum_n;
	logic        valid_s2;
	logic [CHECK_W-1:0] value_s2;
	logic        take;

	assign take = item_s1.valid && advance;

	always_comb begin
		shift_n = crc_next(shift_q, item_s1.data_bit, crc_mode);
		byte_n  = byte_q;
		pos_n   = pos_q;
		sum_n   = sum_q;
		if (crc_mode == MODE_SUM31) begin
			byte_n = {byte_q[6:0], item_s1.data_bit};
			if (pos_q == 3'd7) begin
				sum_n  = sum_mod31(sum_q, byte_n);
				byte_n = '0;
				pos_n  = '0;
			end else begin
				pos_n = pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			byte_q  <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
		end else if (take) begin
			if (item_s1.last_bit) begin
				shift_q <= '0;
				byte_q  <= '0;
				pos_q   <= '0;
				sum_q   <= '0;
			end else begin
				shift_q <= shift_n;
				byte_q  <= byte_n;
				pos_q   <= pos_n;
				sum_q   <= sum_n;
			end
		end
	end

	// result register; it only moves when empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= item_s1.valid && item_s1.last_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last_bit) value_s2 <= check_out(shift_n, sum_n, crc_mode);
	end

	assign res_valid   = valid_s2;
	assign check_value = value_s2;

endmodule

`default_nettype wire

### sv/multi_mode_serial_crc_unit.sv
// ----------------------------------------------------------------------------
// multi_mode_serial_crc_unit
// bit-serial check engine: crc-16 ccitt, crc-9, crc-32, crc-7, crc-8, byte sum mod 31
// ----------------------------------------------------------------------------
// dout.valid rises once a last_bit transfer accepted into the input register has moved on
// into the result register; a held result can delay that move
// throughput: one bit per cycle while no result is held, set by the shift update in the engine
// a held result does not stop input: the input stage keeps taking bits until both
// the input register and the result register are full
// reset (arst_n low): mode returns to ccitt16, check state cleared, no result pending
`default_nettype none

module multi_mode_serial_crc_unit
	import mmsc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	mmsc_bit_if.sink               din,
	mmsc_res_if.source             dout,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	logic [MODE_W-1:0] crc_mode;
	bit_item_t         item_s1;
	logic              res_valid;
	logic              advance;

	// scheme select register
	mmsc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.crc_mode (crc_mode)
	);

	// the input stage drains whenever the result register is free or being taken
	assign advance   = !res_valid || dout.ready;
	assign din.ready = !item_s1.valid || advance;

	// input register: one accepted transfer waits here for the engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (din.ready) begin
			item_s1.valid <= din.valid;
			if (din.valid) begin
				item_s1.data_bit <= din.data_bit;
				item_s1.last_bit <= din.last_bit;
			end
		end
	end

	// check state and result register
	mmsc_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.crc_mode    (crc_mode),
		.item_s1     (item_s1),
		.advance     (advance),
		.res_valid   (res_valid),
		.check_value (dout.check_value)
	);

	assign dout.valid = res_valid;

endmodule

`default_nettype wire

### sv/mmsc_checker.sv
// ----------------------------------------------------------------------------
// mmsc_checker
// port-level checks of the serial check unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module mmsc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        din_valid,
	input wire logic        din_ready,
	input wire logic        din_last,
	input wire logic        dout_valid,
	input wire logic        dout_ready,
	input wire logic [31:0] dout_value
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dout_valid && !dout_ready |=> dout_valid && $stable(dout_value))
		else $error("result changed while stalled");

	// no result while in reset
	a_reset: assert property (@(posedge clk) !arst_n |-> !dout_valid)
		else $error("result valid during reset");

	// a result appears only for an earlier accepted final bit
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dout_valid) |-> $past(din_valid && din_ready && din_last, 2))
		else $error("result without a final bit");

	// a final bit always yields a pending result
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		din_valid && din_ready && din_last |-> ##2 dout_valid)
		else $error("final bit produced no result");

endmodule

bind multi_mode_serial_crc_unit mmsc_checker u_mmsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.din_valid  (din.valid),
	.din_ready  (din.ready),
	.din_last   (din.last_bit),
	.dout_valid (dout.valid),
	.dout_ready (dout.ready),
	.dout_value (dout.check_value)
);

`default_nettype wire
